// ----- hw/rtl/hlg_pkg.sv -----
// ----------------------------------------------------------------------------
// Core hotplug load governor package
// Shared types, codes, constants and helper functions for the governor.
// ----------------------------------------------------------------------------
package hlg_pkg;

    // Number of cores the block is built for (2 to 4).
    localparam int NUM_CORES = 4;

    localparam int CORE_W   = $clog2(NUM_CORES);
    localparam int CNT_W    = $clog2(NUM_CORES + 1);
    localparam int MASK_X_W = (NUM_CORES > 4) ? NUM_CORES : 4;
    localparam int CORE_X_W = (CORE_W > 2) ? CORE_W : 2;

    localparam int THR_W   = 16;
    localparam int HOLD_W  = 8;
    localparam int PRES_W  = 3;
    localparam int DELAY_W = 8;
    localparam int CFG_IDX_W = 3;

    // Input item kinds.
    typedef enum logic [1:0] {
        KIND_SAMPLE  = 2'd0,
        KIND_SUSPEND = 2'd1,
        KIND_RESUME  = 2'd2,
        KIND_UNUSED  = 2'd3
    } kind_t;

    // Result actions.
    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_ALL_ON  = 3'd1,
        ACT_ONE_ON  = 3'd2,
        ACT_ONE_OFF = 3'd3,
        ACT_SUSPEND = 3'd4,
        ACT_RESUME  = 3'd5
    } action_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ALL_ON_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_ON_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_OFF_THR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ON_HOLD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_HOLD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CORES_PRES  = 3'd5;

    // Reset values.
    localparam logic [THR_W-1:0]  ALL_ON_THR_RST  = 16'd600;
    localparam logic [THR_W-1:0]  ONE_ON_THR_RST  = 16'd200;
    localparam logic [THR_W-1:0]  ONE_OFF_THR_RST = 16'd70;
    localparam logic [HOLD_W-1:0] ON_HOLD_RST     = 8'd3;
    localparam logic [HOLD_W-1:0] OFF_HOLD_RST    = 8'd5;
    localparam logic [PRES_W-1:0] CORES_PRES_RST  = 3'd4;
    localparam logic [HOLD_W-1:0] HOLD_CNT_RST    = 8'd1;
    localparam logic [HOLD_W-1:0] HOLD_CNT_MAX    = 8'd255;

    // Sampling delays in milliseconds.
    localparam logic [DELAY_W-1:0] DELAY_FAST   = 8'd100;
    localparam logic [DELAY_W-1:0] DELAY_SLOW   = 8'd200;
    localparam logic [DELAY_W-1:0] DELAY_RESUME = 8'd10;
    localparam logic [DELAY_W-1:0] DELAY_NONE   = 8'd0;

    typedef logic [NUM_CORES-1:0] core_mask_t;

    // Live configuration seen by the decision logic.
    typedef struct packed {
        logic [THR_W-1:0]  all_on_thr;
        logic [THR_W-1:0]  one_on_thr;
        logic [THR_W-1:0]  one_off_thr;
        logic [HOLD_W-1:0] on_hold;
        logic [HOLD_W-1:0] off_hold;
        logic [CNT_W-1:0]  present_cnt;
    } cfg_t;

    // Notice of a write to the present-core count.
    typedef struct packed {
        logic             wr;
        logic [CNT_W-1:0] cnt;
    } pres_upd_t;

    // One result word.
    typedef struct packed {
        action_t           action;
        logic [1:0]        changed_core;
        logic [3:0]        online_mask;
        logic [2:0]        online_count;
        logic [DELAY_W-1:0] next_delay_ms;
    } result_t;

    // Clamp a raw present-core field to 1 .. NUM_CORES.
    function automatic logic [CNT_W-1:0] present_count(input logic [PRES_W-1:0] raw);
        logic [CNT_W-1:0] n;
        if (raw == '0) begin
            n = CNT_W'(1);
        end else if (int'(raw) > NUM_CORES) begin
            n = CNT_W'(NUM_CORES);
        end else begin
            n = CNT_W'(raw);
        end
        return n;
    endfunction

    function automatic core_mask_t present_mask(input logic [CNT_W-1:0] cnt);
        core_mask_t m;
        for (int i = 0; i < NUM_CORES; i++) begin
            m[i] = (i < int'(cnt));
        end
        return m;
    endfunction

    function automatic logic [CNT_W-1:0] popcount(input core_mask_t m);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < NUM_CORES; i++) begin
            c = c + CNT_W'(m[i]);
        end
        return c;
    endfunction

    // Lowest nonzero core below avail whose online bit equals want.
    function automatic logic [CORE_W-1:0] lowest_core(input core_mask_t m,
                                                      input logic [CNT_W-1:0] avail,
                                                      input logic want);
        logic [CORE_W-1:0] idx;
        logic              found;
        idx   = '0;
        found = 1'b0;
        for (int i = 1; i < NUM_CORES; i++) begin
            if (!found && (i < int'(avail)) && (m[i] == want)) begin
                found = 1'b1;
                idx   = CORE_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ----- hw/rtl/hlg_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Governor configuration registers
// Holds the thresholds, hold counts and present-core count written over the
// configuration channel.
// ----------------------------------------------------------------------------
module hlg_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hlg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hlg_pkg::THR_W-1:0]     cfg_data,
    output hlg_pkg::cfg_t                 cfg,
    output hlg_pkg::pres_upd_t            pres_upd
);
    import hlg_pkg::*;

    logic [THR_W-1:0]  all_on_thr_reg;
    logic [THR_W-1:0]  one_on_thr_reg;
    logic [THR_W-1:0]  one_off_thr_reg;
    logic [HOLD_W-1:0] on_hold_reg;
    logic [HOLD_W-1:0] off_hold_reg;
    logic [PRES_W-1:0] pres_reg;
    logic              wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_on_thr_reg  <= ALL_ON_THR_RST;
            one_on_thr_reg  <= ONE_ON_THR_RST;
            one_off_thr_reg <= ONE_OFF_THR_RST;
            on_hold_reg     <= ON_HOLD_RST;
            off_hold_reg    <= OFF_HOLD_RST;
            pres_reg        <= CORES_PRES_RST;
        end
        else if (wr)
        begin
            case (cfg_index)
                REG_ALL_ON_THR:  all_on_thr_reg  <= cfg_data;
                REG_ONE_ON_THR:  one_on_thr_reg  <= cfg_data;
                REG_ONE_OFF_THR: one_off_thr_reg <= cfg_data;
                REG_ON_HOLD:     on_hold_reg     <= cfg_data[HOLD_W-1:0];
                REG_OFF_HOLD:    off_hold_reg    <= cfg_data[HOLD_W-1:0];
                REG_CORES_PRES:  pres_reg        <= cfg_data[PRES_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        cfg.all_on_thr  = all_on_thr_reg;
        cfg.one_on_thr  = one_on_thr_reg;
        cfg.one_off_thr = one_off_thr_reg;
        cfg.on_hold     = on_hold_reg;
        cfg.off_hold    = off_hold_reg;
        cfg.present_cnt = present_count(pres_reg);
        // The engine trims its online mask in the same cycle as the write.
        pres_upd.wr     = wr && (cfg_index == REG_CORES_PRES);
        pres_upd.cnt    = present_count(cfg_data[PRES_W-1:0]);
    end

endmodule

// ----- hw/rtl/hlg_engine.sv -----
// ----------------------------------------------------------------------------
// Governor decision engine
// Keeps the online mask, hold counters and period, and works out the result
// of one item combinationally.
// ----------------------------------------------------------------------------
module hlg_engine
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  hlg_pkg::kind_t             kind,
    input  logic [hlg_pkg::THR_W-1:0]  load_avg,
    input  hlg_pkg::cfg_t              cfg,
    input  hlg_pkg::pres_upd_t         pres_upd,
    output hlg_pkg::result_t           result
);
    import hlg_pkg::*;

    core_mask_t        online_reg, online_next;
    logic [HOLD_W-1:0] high_cnt_reg, high_cnt_next;
    logic [HOLD_W-1:0] low_cnt_reg, low_cnt_next;
    logic              slow_reg, slow_next;

    core_mask_t        pmask;
    core_mask_t        mask_new;
    logic [CNT_W-1:0]  online_cnt;
    logic [CNT_W-1:0]  new_cnt;
    logic [CORE_W-1:0] up_core, down_core, core_sel;
    action_t           action;
    logic [DELAY_W-1:0] delay;
    logic [MASK_X_W-1:0] mask_x;
    logic [CORE_X_W-1:0] core_x;

    always_comb
    begin
        pmask      = present_mask(cfg.present_cnt);
        online_cnt = popcount(online_reg);
        up_core    = lowest_core(online_reg, cfg.present_cnt, 1'b0);
        down_core  = lowest_core(online_reg, cfg.present_cnt, 1'b1);

        mask_new      = online_reg;
        high_cnt_next = high_cnt_reg;
        low_cnt_next  = low_cnt_reg;
        slow_next     = slow_reg;
        action        = ACT_NONE;
        core_sel      = '0;
        delay         = slow_reg ? DELAY_SLOW : DELAY_FAST;

        case (kind)
            KIND_SAMPLE:
            begin
                if ((load_avg >= cfg.all_on_thr) && (online_cnt < cfg.present_cnt))
                begin
                    mask_new = pmask;
                    action   = ACT_ALL_ON;
                end
                else if ((load_avg >= cfg.one_on_thr) && (online_cnt < cfg.present_cnt))
                begin
                    if (high_cnt_reg >= cfg.on_hold)
                    begin
                        mask_new[up_core] = 1'b1;
                        core_sel  = up_core;
                        action    = ACT_ONE_ON;
                        slow_next = 1'b1;
                    end
                    else if (high_cnt_reg != HOLD_CNT_MAX)
                    begin
                        high_cnt_next = high_cnt_reg + 1'b1;
                    end
                    low_cnt_next = HOLD_CNT_RST;
                end
                else if ((load_avg <= cfg.one_off_thr) && (online_cnt > CNT_W'(1)))
                begin
                    if (low_cnt_reg >= cfg.off_hold)
                    begin
                        mask_new[down_core] = 1'b0;
                        core_sel  = down_core;
                        action    = ACT_ONE_OFF;
                        slow_next = 1'b0;
                    end
                    else if (low_cnt_reg != HOLD_CNT_MAX)
                    begin
                        low_cnt_next = low_cnt_reg + 1'b1;
                    end
                    high_cnt_next = HOLD_CNT_RST;
                end
                // The period may have just changed; the new one is reported.
                delay = slow_next ? DELAY_SLOW : DELAY_FAST;
            end
            KIND_SUSPEND:
            begin
                mask_new = '0;
                action   = ACT_SUSPEND;
                delay    = DELAY_NONE;
            end
            KIND_RESUME:
            begin
                mask_new = pmask;
                action   = ACT_RESUME;
                delay    = DELAY_RESUME;
            end
            default:
            begin
            end
        endcase

        // Core 0 never goes offline.
        mask_new[0] = 1'b1;
        new_cnt     = popcount(mask_new);

        mask_x = MASK_X_W'(mask_new);
        core_x = CORE_X_W'(core_sel);
        result.action        = action;
        result.changed_core  = core_x[1:0];
        result.online_mask   = mask_x[3:0];
        result.online_count  = 3'(new_cnt);
        result.next_delay_ms = delay;

        online_next = online_reg;
        if (pres_upd.wr)
        begin
            online_next    = online_reg & present_mask(pres_upd.cnt);
            online_next[0] = 1'b1;
        end
        else if (step)
        begin
            online_next = mask_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            online_reg   <= present_mask(present_count(CORES_PRES_RST));
            high_cnt_reg <= HOLD_CNT_RST;
            low_cnt_reg  <= HOLD_CNT_RST;
            slow_reg     <= 1'b0;
        end
        else
        begin
            online_reg <= online_next;
            if (step)
            begin
                high_cnt_reg <= high_cnt_next;
                low_cnt_reg  <= low_cnt_next;
                slow_reg     <= slow_next;
            end
        end
    end

endmodule

// ----- hw/rtl/core_hotplug_load_governor_unit.sv -----
// ----------------------------------------------------------------------------
// Core hotplug load governor
// Decides which processor cores are powered from load samples and from
// suspend and resume events, giving one result word per input word.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  s_*       in         s_tvalid/s_tready  tuser: kind; tdata: load_avg
//  m_*       out        m_tvalid/m_tready  tuser: action; tdata: core, mask,
//                                          count, next delay
//  cfg_*     in         cfg_valid/cfg_ready cfg_index, cfg_data (16 bit)
//
// Each input word is captured in an input register, decided combinationally
// by the engine, and the result lands in an output register when the held
// word moves on. One word per cycle is sustained while m_tready stays high.
// The input register keeps accepting while a result waits, as long as that
// result is taken in the same cycle the held word moves on.
// rst_n clears all control state asynchronously; the configuration returns to
// its reset values and every present core is marked online.
// Configuration writes are always accepted, as cfg_ready is tied high, and
// take effect on the next word.
//
module core_hotplug_load_governor_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Input words
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [15:0] load_avg
    input  logic [1:0]                    s_tuser,   // [1:0] kind
    // Result words
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // [1:0] changed_core,
                                                     // [5:2] online_mask,
                                                     // [8:6] online_count,
                                                     // [16:9] next_delay_ms,
                                                     // [23:17] zero
    output logic [2:0]                    m_tuser,   // [2:0] action
    // Configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hlg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data
);
    import hlg_pkg::*;

    cfg_t      cfg;
    pres_upd_t pres_upd;
    result_t   result;

    // Input register.
    logic             in_vld_reg;
    kind_t            in_kind_reg;
    logic [THR_W-1:0] in_load_reg;

    // Output register.
    logic             out_vld_reg, out_vld_next;
    result_t          out_res_reg;

    logic             advance;
    logic             take_in;

    // The held word moves to the output once the output is free or drained.
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign take_in  = s_tvalid && s_tready;

    hlg_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .pres_upd  (pres_upd)
    );

    hlg_engine u_engine
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .kind     (in_kind_reg),
        .load_avg (in_load_reg),
        .cfg      (cfg),
        .pres_upd (pres_upd),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (take_in)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_kind_reg <= kind_t'(s_tuser);
            in_load_reg <= s_tdata;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_res_reg.action;
    assign m_tdata  = {7'b0, out_res_reg.next_delay_ms, out_res_reg.online_count,
                       out_res_reg.online_mask, out_res_reg.changed_core};

endmodule

// ----- hw/rtl/hlg_checker.sv -----
// ----------------------------------------------------------------------------
// Governor port checker
// Watches the top-level ports of the governor and flags broken results.
// ----------------------------------------------------------------------------
module hlg_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [2:0]  m_tuser
);
    import hlg_pkg::*;

    // A waiting result word must not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // Core 0 is online in every result.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2])
        else $error("core 0 reported offline");

    // Suspend leaves only core 0 and schedules no sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ACT_SUSPEND) |->
            (m_tdata[5:2] == 4'b0001) && (m_tdata[8:6] == 3'd1) &&
            (m_tdata[16:9] == DELAY_NONE))
        else $error("suspend result inconsistent");

    // Resume gives the short delay.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ACT_RESUME) |-> (m_tdata[16:9] == DELAY_RESUME))
        else $error("resume delay wrong");

    // Only single-core switches name a core.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ACT_ONE_ON) && (m_tuser != ACT_ONE_OFF) |->
            (m_tdata[1:0] == 2'd0))
        else $error("changed core set without a single-core switch");

endmodule

bind core_hotplug_load_governor_unit hlg_checker u_hlg_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Testbench for the core hotplug load governor
// Drives load samples and suspend and resume events through the stream
// ports under several register settings and random idling on both sides.
// A scoreboard predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import hlg_pkg::*;

class core_power_scoreboard;

    // Register copy
    logic [THR_W-1:0]     all_on_thr;
    logic [THR_W-1:0]     one_on_thr;
    logic [THR_W-1:0]     one_off_thr;
    logic [HOLD_W-1:0]    on_hold;
    logic [HOLD_W-1:0]    off_hold;
    logic [PRES_W-1:0]    pres_raw;

    // Governor state copy
    core_mask_t           online_bits;
    logic [HOLD_W-1:0]    high_cnt;
    logic [HOLD_W-1:0]    low_cnt;
    logic [DELAY_W-1:0]   period;

    result_t              pending_decisions[$];
    int                   errors;

    function new();
        all_on_thr  = ALL_ON_THR_RST;
        one_on_thr  = ONE_ON_THR_RST;
        one_off_thr = ONE_OFF_THR_RST;
        on_hold     = ON_HOLD_RST;
        off_hold    = OFF_HOLD_RST;
        pres_raw    = CORES_PRES_RST;
        online_bits = avail_mask();
        high_cnt    = HOLD_CNT_RST;
        low_cnt     = HOLD_CNT_RST;
        period      = DELAY_FAST;
        errors      = 0;
    endfunction

    function int avail_cores();
        if (pres_raw == '0)
            return 1;
        if (int'(pres_raw) > NUM_CORES)
            return NUM_CORES;
        return int'(pres_raw);
    endfunction

    function core_mask_t avail_mask();
        core_mask_t m;
        int         n;
        n = avail_cores();
        for (int i = 0; i < NUM_CORES; i++)
            m[i] = (i < n);
        return m;
    endfunction

    function int pending();
        return pending_decisions.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        case (idx)
            REG_ALL_ON_THR:  all_on_thr  = data;
            REG_ONE_ON_THR:  one_on_thr  = data;
            REG_ONE_OFF_THR: one_off_thr = data;
            REG_ON_HOLD:     on_hold     = data[HOLD_W-1:0];
            REG_OFF_HOLD:    off_hold    = data[HOLD_W-1:0];
            REG_CORES_PRES:
            begin
                pres_raw    = data[PRES_W-1:0];
                online_bits = (online_bits & avail_mask()) | core_mask_t'(1);
            end
            default: ;
        endcase
    endfunction

    // Works out the decision for one word and moves the state on.
    function result_t decide_cores(kind_t kind, logic [15:0] load);
        result_t    r;
        core_mask_t pmask;
        int         avail;
        int         online;
        logic       found;
        pmask  = avail_mask();
        avail  = avail_cores();
        online = $countones(online_bits);
        found  = 1'b0;
        r      = '0;
        r.action = ACT_NONE;
        case (kind)
            KIND_SAMPLE:
            begin
                if (load >= all_on_thr && online < avail) begin
                    online_bits = pmask;
                    r.action    = ACT_ALL_ON;
                end else if (load >= one_on_thr && online < avail) begin
                    if (high_cnt >= on_hold) begin
                        for (int i = 1; i < avail; i++) begin
                            if (!found && !online_bits[i]) begin
                                online_bits[i]  = 1'b1;
                                r.changed_core  = 2'(i);
                                found           = 1'b1;
                            end
                        end
                        r.action = ACT_ONE_ON;
                        period   = DELAY_SLOW;
                    end else if (high_cnt != HOLD_CNT_MAX) begin
                        high_cnt = high_cnt + 1'b1;
                    end
                    low_cnt = HOLD_CNT_RST;
                end else if (load <= one_off_thr && online > 1) begin
                    if (low_cnt >= off_hold) begin
                        for (int i = 1; i < avail; i++) begin
                            if (!found && online_bits[i]) begin
                                online_bits[i]  = 1'b0;
                                r.changed_core  = 2'(i);
                                found           = 1'b1;
                            end
                        end
                        r.action = ACT_ONE_OFF;
                        period   = DELAY_FAST;
                    end else if (low_cnt != HOLD_CNT_MAX) begin
                        low_cnt = low_cnt + 1'b1;
                    end
                    high_cnt = HOLD_CNT_RST;
                end
                r.next_delay_ms = period;
            end
            KIND_SUSPEND:
            begin
                online_bits     = core_mask_t'(1);
                r.action        = ACT_SUSPEND;
                r.next_delay_ms = DELAY_NONE;
            end
            KIND_RESUME:
            begin
                online_bits     = pmask;
                r.action        = ACT_RESUME;
                r.next_delay_ms = DELAY_RESUME;
            end
            default: r.next_delay_ms = period;
        endcase
        online_bits[0] = 1'b1;
        r.online_mask  = 4'(online_bits);
        r.online_count = 3'($countones(online_bits));
        return r;
    endfunction

    function void note_word(kind_t kind, logic [15:0] load);
        pending_decisions.push_back(decide_cores(kind, load));
    endfunction

    function void compare_field(string name, int want, int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    function void check_word(logic [2:0] action, logic [23:0] data);
        result_t want;
        if (pending_decisions.size() == 0) begin
            errors++;
            $display("%0t: result word with nothing expected, action %0d, data 0x%06h",
                     $time, action, data);
            return;
        end
        want = pending_decisions.pop_front();
        compare_field("action", int'(want.action), int'(action));
        compare_field("changed_core", int'(want.changed_core), int'(data[1:0]));
        compare_field("online_mask", int'(want.online_mask), int'(data[5:2]));
        compare_field("online_count", int'(want.online_count), int'(data[8:6]));
        compare_field("next_delay_ms", int'(want.next_delay_ms), int'(data[16:9]));
        compare_field("tdata padding", 0, int'(data[23:17]));
    endfunction

endclass

module tb_top;

    // Register indexes that decode to nothing; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    // Generous ceiling on the run length for a few hundred words.
    localparam int CYCLE_LIMIT = 200000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata   = '0;
    logic [1:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [23:0]          m_tdata;
    logic [2:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data  = '0;

    core_power_scoreboard sb = new();
    idle_mode_t           idle_mode = IDLE_NONE;
    int                   words_sent = 0;
    int                   cycle_count = 0;

    core_hotplug_load_governor_unit DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // The receiver stalls at random in its idling phases; in the others it
    // takes every result word as soon as it appears.
    always @(posedge clk)
    begin
        case (idle_mode)
            IDLE_RECEIVER: m_tready <= ($urandom_range(99) >= 77);
            IDLE_BOTH:     m_tready <= ($urandom_range(99) >= 26);
            default:       m_tready <= 1'b1;
        endcase
    end

    // Every result word accepted at this edge is checked against the oldest
    // prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tuser, m_tdata);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Presents one input word, after a random gap when the sender idles, and
    // returns in the time step of the edge at which it was accepted. Each
    // step sees a single assignment to s_tvalid, so a valid that stays high
    // across back-to-back words is never lowered and raised in one step.
    task automatic send_word(input kind_t kind, input logic [15:0] load);
        int idle_pct;
        idle_pct = (idle_mode == IDLE_SENDER) ? 77 : (idle_mode == IDLE_BOTH) ? 26 : 0;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= load;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_word(kind, load);
        words_sent++;
    endtask

    // Holds the sender back until every predicted word has come out. Valid
    // is lowered only when there is something to wait for, so that the
    // following word never sees valid lowered and raised in one step.
    task automatic wait_results_drained();
        while (sb.pending() != 0) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // Programs a full register set. Only called with the block idle, so the
    // new values apply cleanly from the next word on.
    task automatic program_governor(input int all_on, input int one_on, input int one_off,
                                    input int on_hold, input int off_hold, input int present);
        write_reg(REG_ALL_ON_THR, 16'(all_on));
        write_reg(REG_ONE_ON_THR, 16'(one_on));
        write_reg(REG_ONE_OFF_THR, 16'(one_off));
        write_reg(REG_ON_HOLD, 16'(on_hold));
        write_reg(REG_OFF_HOLD, 16'(off_hold));
        write_reg(REG_CORES_PRES, 16'(present));
        cfg_valid <= 1'b0;
    endtask

    // A load inside [lo, hi], with the two ends favoured; an empty band
    // falls back to any load at all.
    function automatic logic [15:0] band_load(input int lo, input int hi);
        int sel;
        if (lo > hi)
            return 16'($urandom_range(65535));
        sel = $urandom_range(7);
        if (sel == 0)
            return 16'(lo);
        if (sel == 1)
            return 16'(hi);
        return 16'($urandom_range(hi, lo));
    endfunction

    // Random words in runs of one load band, so that the hold counters get
    // long enough stretches of high or low load to fire. high_pct sets how
    // often a run sits in the band that brings single cores online; the
    // rest is spread over the low, all-on, dead and unrestricted bands.
    // Suspend, resume and the unused kind are mixed in throughout.
    task automatic run_random(input int count, input int run_max, input int high_pct);
        int          left;
        int          run;
        int          band;
        int          pick;
        int          hi_top;
        logic [15:0] load;
        kind_t       kind;
        left = count;
        run  = 0;
        band = 0;
        while (left > 0) begin
            if (run == 0) begin
                run  = $urandom_range(run_max, 1);
                band = ($urandom_range(99) < high_pct) ? 0 : $urandom_range(4, 1);
            end
            hi_top = (int'(sb.all_on_thr) > int'(sb.one_on_thr)) ?
                     int'(sb.all_on_thr) - 1 : 65535;
            case (band)
                0:       load = band_load(int'(sb.one_on_thr), hi_top);
                1:       load = band_load(0, int'(sb.one_off_thr));
                2:       load = band_load(int'(sb.all_on_thr), 65535);
                3:       load = band_load(int'(sb.one_off_thr) + 1, int'(sb.one_on_thr) - 1);
                default: load = 16'($urandom_range(65535));
            endcase
            pick = $urandom_range(99);
            if (pick < 4)
                kind = KIND_SUSPEND;
            else if (pick < 8)
                kind = KIND_RESUME;
            else if (pick < 10)
                kind = KIND_UNUSED;
            else
                kind = KIND_SAMPLE;
            // Idling changes every 25 words, so the run as a whole sees every mode,
            // including stretches with no idling at all.
            idle_mode = idle_mode_t'((words_sent / 25) % 4);
            if ($urandom_range(99) < 2)
                wait_results_drained();
            send_word(kind, load);
            left--;
            run--;
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset settings: all four cores online,
        // thresholds 600, 200 and 70, holds of 3 and 5 samples.
        send_word(KIND_SAMPLE, 16'd0);       // low load counts but does not yet switch
        send_word(KIND_SAMPLE, 16'd70);      // exactly on the offline threshold
        send_word(KIND_SAMPLE, 16'd71);      // dead band
        send_word(KIND_SAMPLE, 16'hFFFF);    // all cores already on: no action
        send_word(KIND_SUSPEND, 16'hFFFF);
        send_word(KIND_SAMPLE, 16'd600);     // sample while suspended: all on
        send_word(KIND_SUSPEND, 16'd0);
        send_word(KIND_SAMPLE, 16'd599);     // high load, hold count climbing
        send_word(KIND_SAMPLE, 16'd200);
        send_word(KIND_SAMPLE, 16'd199);     // dead band leaves the counters alone
        send_word(KIND_SAMPLE, 16'd200);     // hold reached: core 1 on, slow period
        send_word(KIND_SAMPLE, 16'hFFFF);    // all-on wins over one-on
        send_word(KIND_UNUSED, 16'h5A5A);    // unused kind keeps the period
        send_word(KIND_RESUME, 16'hA5A5);
        // Low load from a fresh counter: four samples to count up, then
        // one core off per sample, since the counter is not cleared by a
        // switch, until only core 0 is left.
        repeat (9)
            send_word(KIND_SAMPLE, 16'd0);
        send_word(KIND_SAMPLE, 16'hFFFF);

        // Reset settings written back explicitly.
        wait_results_drained();
        program_governor(600, 200, 70, 3, 5, 4);
        run_random(60, 8, 35);

        // Extremes: present count 0 acts as one core and drops the others,
        // zero holds, every threshold pinned to an end.
        wait_results_drained();
        program_governor(65535, 0, 65535, 0, 0, 0);
        run_random(30, 6, 35);

        // Every sample meets the all-on threshold; present count 7 acts as four.
        wait_results_drained();
        program_governor(0, 0, 0, 255, 255, 7);
        run_random(40, 6, 35);

        // Overlapping one-on and one-off bands check the priority order;
        // the unmapped indexes take random data and must change nothing.
        wait_results_drained();
        program_governor(65535, 500, 800, 1, 1, 3);
        @(posedge clk);
        write_reg(REG_UNMAPPED_LO, 16'($urandom_range(65535)));
        write_reg(REG_UNMAPPED_HI, 16'($urandom_range(65535)));
        cfg_valid <= 1'b0;
        run_random(60, 8, 35);

        // Longest holds with long high runs, so the high counter reaches its ceiling
        // and then switches a core on at every further high sample while one is offline.
        wait_results_drained();
        program_governor(40000, 20000, 10000, 255, 255, 6);
        run_random(280, 300, 80);

        // Two cores, one-on and one-off thresholds adjacent, zero off hold.
        wait_results_drained();
        program_governor(1000, 300, 299, 2, 0, 2);
        run_random(60, 8, 35);

        wait_results_drained();
        idle_mode = IDLE_NONE;
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
